/* hdl/vat_pkg.sv */
// Shared widths, register indexes and stage records for the vertex transform.
package vat_pkg;

  localparam int CFG_W   = 64;
  localparam int NUM_ROW = 6;
  localparam int POS_W   = 32;
  localparam int NRM_W   = 16;
  localparam int PRD_W   = 64;
  localparam int PSUM_W  = 66;
  localparam int FLR_W   = PSUM_W - 16;
  localparam int TOT_W   = FLR_W + 1;
  localparam int NPRD_W  = 48;
  localparam int NSUM_W  = 50;
  localparam int LEAD_W  = 6;
  localparam int MAG_W   = 30;
  localparam int SQ_W    = 60;
  localparam int RAD_W   = 62;
  localparam int ROOT_W  = 31;
  localparam int QUO_W   = 15;
  localparam int NUM_W   = 45;
  localparam int DATA_W  = 144;
  localparam int ADDR_W  = 3;

  localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;
  localparam logic [QUO_W-1:0] UNIT_Q  = 15'd16384;

  localparam logic [CFG_W-1:0] RST_ROW0_C01 = 64'h0000_0000_0001_0000;
  localparam logic [CFG_W-1:0] RST_ROW1_C01 = 64'h0001_0000_0000_0000;
  localparam logic [CFG_W-1:0] RST_ROW2_C23 = 64'h0000_0000_0001_0000;

  typedef enum logic [ADDR_W-1:0] {
    CFG_ROW0_C01 = 3'd0,
    CFG_ROW0_C23 = 3'd1,
    CFG_ROW1_C01 = 3'd2,
    CFG_ROW1_C23 = 3'd3,
    CFG_ROW2_C01 = 3'd4,
    CFG_ROW2_C23 = 3'd5,
    CFG_NRM_EN   = 3'd6
  } cfg_idx_t;

  // Pipeline control shared by every stage.
  typedef struct packed {
    logic vld;
    logic adv;
  } vat_ctl_t;

  // Everything that rides alongside the square root and the divider.
  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][NRM_W-1:0] nrm_in;
    logic                  last;
    logic                  en;
    logic                  zero;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } vat_side_t;

endpackage

/* hdl/vat_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module vat_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vat_pkg::vat_ctl_t           ctl_i,
  input  logic [vat_pkg::RAD_W-1:0]   rad_i,
  input  vat_pkg::vat_side_t          side_i,
  output logic                        vld_o,
  output logic [vat_pkg::ROOT_W-1:0]  root_o,
  output vat_pkg::vat_side_t          side_o
);

  localparam int STEPS = vat_pkg::ROOT_W;
  localparam int REM_W = vat_pkg::ROOT_W + 1;

  logic                       vld_r  [STEPS];
  logic [vat_pkg::RAD_W-1:0]  rad_r  [STEPS];
  logic [REM_W-1:0]           rem_r  [STEPS];
  logic [vat_pkg::ROOT_W-1:0] root_r [STEPS];
  vat_pkg::vat_side_t         side_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                       vld_in;
    logic [vat_pkg::RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]           rem_in;
    logic [vat_pkg::ROOT_W-1:0] root_in;
    vat_pkg::vat_side_t         side_in;
    logic [REM_W+1:0]           cur;
    logic [REM_W+1:0]           trial;
    logic                       ge;
    logic [REM_W-1:0]           rem_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = ctl_i.vld;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign cur     = {rem_in, rad_in[vat_pkg::RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_in, 2'b01};
    assign ge      = (cur >= trial);
    assign rem_nxt = ge ? REM_W'(cur - trial) : REM_W'(cur);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl_i.adv) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.adv) begin
        rad_r[k]  <= rad_in << 2;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= {root_in[vat_pkg::ROOT_W-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[STEPS-1];
  assign root_o = root_r[STEPS-1];
  assign side_o = side_r[STEPS-1];

  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[STEPS-1] |-> rem_r[STEPS-1] <= {root_r[STEPS-1], 1'b0})
    else $error("square root remainder exceeds twice the root");

endmodule

/* hdl/vat_recip_div.sv */
// Three-lane pipelined divider: rounded mag*16384/len, one quotient bit per stage.
module vat_recip_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  vat_pkg::vat_ctl_t                    ctl_i,
  input  logic [vat_pkg::ROOT_W-1:0]           len_i,
  input  vat_pkg::vat_side_t                   side_i,
  output logic                                 vld_o,
  output logic [2:0][vat_pkg::QUO_W-1:0]       quo_o,
  output vat_pkg::vat_side_t                   side_o
);

  localparam int STEPS = vat_pkg::QUO_W;
  localparam int REM_W = vat_pkg::ROOT_W;
  localparam int FRAC  = vat_pkg::QUO_W - 1;

  logic                                  pv_r;
  logic [vat_pkg::ROOT_W-1:0]            plen_r;
  logic [2:0][REM_W-1:0]                 prem_r;
  logic [2:0][vat_pkg::QUO_W-1:0]        plow_r;
  vat_pkg::vat_side_t                    pside_r;
  logic [2:0][vat_pkg::NUM_W-1:0]        num;

  logic                                  vld_r  [STEPS];
  logic [vat_pkg::ROOT_W-1:0]            len_r  [STEPS];
  logic [2:0][REM_W-1:0]                 rem_r  [STEPS];
  logic [2:0][vat_pkg::QUO_W-1:0]        low_r  [STEPS];
  logic [2:0][vat_pkg::QUO_W-1:0]        quo_r  [STEPS];
  vat_pkg::vat_side_t                    side_r [STEPS];

  // Numerator carries the half-divisor for round half away from zero.
  for (genvar i = 0; i < 3; i++) begin : g_num
    assign num[i] = vat_pkg::NUM_W'({side_i.mag[i], {FRAC{1'b0}}})
                  + vat_pkg::NUM_W'(len_i >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (ctl_i.adv) begin
      pv_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      plen_r  <= len_i;
      pside_r <= side_i;
      for (int i = 0; i < 3; i++) begin
        prem_r[i] <= REM_W'(num[i][vat_pkg::NUM_W-1:vat_pkg::QUO_W]);
        plow_r[i] <= num[i][vat_pkg::QUO_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                            vld_in;
    logic [vat_pkg::ROOT_W-1:0]      len_in;
    logic [2:0][REM_W-1:0]           rem_in;
    logic [2:0][vat_pkg::QUO_W-1:0]  low_in;
    logic [2:0][vat_pkg::QUO_W-1:0]  quo_in;
    vat_pkg::vat_side_t              side_in;
    logic [2:0][REM_W-1:0]           rem_nxt;
    logic [2:0]                      ge;

    if (k == 0) begin : g_first
      assign vld_in  = pv_r;
      assign len_in  = plen_r;
      assign rem_in  = prem_r;
      assign low_in  = plow_r;
      assign quo_in  = '0;
      assign side_in = pside_r;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign len_in  = len_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign low_in  = low_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign side_in = side_r[k-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [REM_W:0] cur;
      assign cur        = {rem_in[i], low_in[i][vat_pkg::QUO_W-1]};
      assign ge[i]      = (cur >= {1'b0, len_in});
      assign rem_nxt[i] = ge[i] ? REM_W'(cur - {1'b0, len_in}) : REM_W'(cur);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl_i.adv) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.adv) begin
        len_r[k]  <= len_in;
        rem_r[k]  <= rem_nxt;
        side_r[k] <= side_in;
        for (int i = 0; i < 3; i++) begin
          low_r[k][i] <= low_in[i] << 1;
          quo_r[k][i] <= {quo_in[i][vat_pkg::QUO_W-2:0], ge[i]};
        end
      end
    end
  end

  assign vld_o  = vld_r[STEPS-1];
  assign quo_o  = quo_r[STEPS-1];
  assign side_o = side_r[STEPS-1];

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[STEPS-1] && !side_r[STEPS-1].zero) |->
      (rem_r[STEPS-1][0] < len_r[STEPS-1]) && (rem_r[STEPS-1][1] < len_r[STEPS-1]) &&
      (rem_r[STEPS-1][2] < len_r[STEPS-1]))
    else $error("divider remainder not below divisor");

endmodule

/* hdl/vertex_affine_transform.sv */
// Top level: affine vertex transform with optional normal renormalization.
// Pipeline: 7 arithmetic stages, 31 square-root stages, 16 divider stages and the
//   output register lie between an accepted request and out_tvalid.
// Throughput: one vertex per cycle; every stage advances together whenever the
//   output register is empty or being taken, so a stall holds the whole pipe.
// Reset: synchronous active-low rst_n clears all valid bits and loads the identity
//   matrix with normal processing off.
module vertex_affine_transform (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [vat_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [vat_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z
  input  logic [vat_pkg::DATA_W-1:0]  in_tdata,
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z
  output logic [vat_pkg::DATA_W-1:0]  out_tdata,
  output logic                        out_tlast
);

  localparam int P_W  = vat_pkg::POS_W;
  localparam int N_W  = vat_pkg::NRM_W;
  localparam int TOPB = vat_pkg::MAG_W - 1;

  logic [vat_pkg::CFG_W-1:0] cfg_r [vat_pkg::NUM_ROW];
  logic                      nrm_en_r;
  logic                      adv;
  vat_pkg::vat_ctl_t         ctl;

  logic [P_W-1:0] coef_w [3][4];
  logic [P_W-1:0] in_pos [3];
  logic [N_W-1:0] in_nrm [3];

  // Stage 1: products
  logic                             s1_vld_r;
  logic signed [vat_pkg::PRD_W-1:0]  s1_pprd_r [3][3];
  logic signed [vat_pkg::NPRD_W-1:0] s1_nprd_r [3][3];
  logic [2:0][N_W-1:0]              s1_nrm_r;
  logic                             s1_last_r;
  // Stage 2: dot products
  logic                              s2_vld_r;
  logic signed [vat_pkg::PSUM_W-1:0] s2_psum_r [3];
  logic signed [vat_pkg::NSUM_W-1:0] s2_nsum_r [3];
  logic [2:0][N_W-1:0]               s2_nrm_r;
  logic                              s2_last_r;
  // Stage 3: position done, normal magnitudes
  logic                            s3_vld_r;
  logic [2:0][P_W-1:0]             s3_pos_r;
  logic [2:0]                      s3_neg_r;
  logic [vat_pkg::NSUM_W-1:0]      s3_mag_r [3];
  logic [2:0][N_W-1:0]             s3_nrm_r;
  logic                            s3_last_r;
  // Stage 4: leading one
  logic                            s4_vld_r;
  logic [2:0][P_W-1:0]             s4_pos_r;
  logic [2:0]                      s4_neg_r;
  logic [vat_pkg::NSUM_W-1:0]      s4_mag_r [3];
  logic [2:0][N_W-1:0]             s4_nrm_r;
  logic                            s4_last_r;
  logic [vat_pkg::LEAD_W-1:0]      s4_lead_r;
  logic                            s4_zero_r;
  // Stages 5..7
  logic                            s5_vld_r;
  vat_pkg::vat_side_t              s5_side_r;
  logic                            s6_vld_r;
  vat_pkg::vat_side_t              s6_side_r;
  logic [vat_pkg::SQ_W-1:0]        s6_sq_r [3];
  logic                            s7_vld_r;
  vat_pkg::vat_side_t              s7_side_r;
  logic [vat_pkg::RAD_W-1:0]       s7_rad_r;

  logic                            sq_vld;
  logic [vat_pkg::ROOT_W-1:0]      sq_root;
  vat_pkg::vat_side_t              sq_side;
  vat_pkg::vat_ctl_t               sq_ctl;
  vat_pkg::vat_ctl_t               dv_ctl;
  logic                            dv_vld;
  logic [2:0][vat_pkg::QUO_W-1:0]  dv_quo;
  vat_pkg::vat_side_t              dv_side;

  logic                            out_tvalid_r;
  logic [vat_pkg::DATA_W-1:0]      out_tdata_r;
  logic                            out_tlast_r;
  logic [vat_pkg::DATA_W-1:0]      out_tdata_nxt;

  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;
  assign ctl       = '{vld: in_tvalid, adv: adv};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[vat_pkg::CFG_ROW0_C01] <= vat_pkg::RST_ROW0_C01;
      cfg_r[vat_pkg::CFG_ROW0_C23] <= '0;
      cfg_r[vat_pkg::CFG_ROW1_C01] <= vat_pkg::RST_ROW1_C01;
      cfg_r[vat_pkg::CFG_ROW1_C23] <= '0;
      cfg_r[vat_pkg::CFG_ROW2_C01] <= '0;
      cfg_r[vat_pkg::CFG_ROW2_C23] <= vat_pkg::RST_ROW2_C23;
      nrm_en_r                     <= 1'b0;
    end else if (cfg_we) begin
      unique case (vat_pkg::cfg_idx_t'(cfg_addr))
        vat_pkg::CFG_ROW0_C01: cfg_r[vat_pkg::CFG_ROW0_C01] <= cfg_wdata;
        vat_pkg::CFG_ROW0_C23: cfg_r[vat_pkg::CFG_ROW0_C23] <= cfg_wdata;
        vat_pkg::CFG_ROW1_C01: cfg_r[vat_pkg::CFG_ROW1_C01] <= cfg_wdata;
        vat_pkg::CFG_ROW1_C23: cfg_r[vat_pkg::CFG_ROW1_C23] <= cfg_wdata;
        vat_pkg::CFG_ROW2_C01: cfg_r[vat_pkg::CFG_ROW2_C01] <= cfg_wdata;
        vat_pkg::CFG_ROW2_C23: cfg_r[vat_pkg::CFG_ROW2_C23] <= cfg_wdata;
        vat_pkg::CFG_NRM_EN:   nrm_en_r                     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_coef
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign coef_w[r][c] = cfg_r[2*r + c/2][P_W*(c%2) +: P_W];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign in_pos[i] = in_tdata[P_W*i +: P_W];
    assign in_nrm[i] = in_tdata[3*P_W + N_W*i +: N_W];
  end

  // Valid chain through the arithmetic stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
    end
  end

  // Stage 1: nine position and nine normal products
  for (genvar r = 0; r < 3; r++) begin : g_s1
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [vat_pkg::PRD_W-1:0]  pprd;
      logic signed [vat_pkg::NPRD_W-1:0] nprd;
      assign pprd = $signed(coef_w[r][c]) * $signed(in_pos[c]);
      assign nprd = $signed(coef_w[r][c]) * $signed(in_nrm[c]);
      always_ff @(posedge clk) begin
        if (adv) begin
          s1_pprd_r[r][c] <= pprd;
          s1_nprd_r[r][c] <= nprd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_nrm_r[i] <= in_nrm[i];
      end
      s1_last_r <= in_tlast;
    end
  end

  // Stage 2: row sums
  for (genvar r = 0; r < 3; r++) begin : g_s2
    logic signed [vat_pkg::PSUM_W-1:0] psum;
    logic signed [vat_pkg::NSUM_W-1:0] nsum;
    assign psum = s1_pprd_r[r][0] + s1_pprd_r[r][1] + s1_pprd_r[r][2];
    assign nsum = s1_nprd_r[r][0] + s1_nprd_r[r][1] + s1_nprd_r[r][2];
    always_ff @(posedge clk) begin
      if (adv) begin
        s2_psum_r[r] <= psum;
        s2_nsum_r[r] <= nsum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_nrm_r  <= s1_nrm_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Stage 3: floor to Q16.16, translate, saturate; normal sign and magnitude
  for (genvar r = 0; r < 3; r++) begin : g_s3
    logic signed [vat_pkg::TOT_W-1:0] tot;
    logic [P_W-1:0]                   pos_nxt;
    logic [vat_pkg::NSUM_W-1:0]       mag_nxt;
    assign tot = $signed(s2_psum_r[r][vat_pkg::PSUM_W-1:16]) + $signed(coef_w[r][3]);
    always_comb begin
      if (tot[vat_pkg::TOT_W-1:P_W-1] == '0 || tot[vat_pkg::TOT_W-1:P_W-1] == '1) begin
        pos_nxt = tot[P_W-1:0];
      end else begin
        pos_nxt = tot[vat_pkg::TOT_W-1] ? vat_pkg::POS_MIN : vat_pkg::POS_MAX;
      end
    end
    assign mag_nxt = s2_nsum_r[r][vat_pkg::NSUM_W-1] ? vat_pkg::NSUM_W'(-s2_nsum_r[r])
                                                     : vat_pkg::NSUM_W'(s2_nsum_r[r]);
    always_ff @(posedge clk) begin
      if (adv) begin
        s3_pos_r[r] <= pos_nxt;
        s3_neg_r[r] <= s2_nsum_r[r][vat_pkg::NSUM_W-1];
        s3_mag_r[r] <= mag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_nrm_r  <= s2_nrm_r;
      s3_last_r <= s2_last_r;
    end
  end

  // Stage 4: position of the leading one over all three magnitudes
  logic [vat_pkg::NSUM_W-1:0] mag_or;
  logic [vat_pkg::LEAD_W-1:0] lead_nxt;

  assign mag_or = s3_mag_r[0] | s3_mag_r[1] | s3_mag_r[2];

  always_comb begin
    lead_nxt = '0;
    for (int b = 0; b < vat_pkg::NSUM_W; b++) begin
      if (mag_or[b]) begin
        lead_nxt = vat_pkg::LEAD_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_pos_r  <= s3_pos_r;
      s4_neg_r  <= s3_neg_r;
      s4_mag_r  <= s3_mag_r;
      s4_nrm_r  <= s3_nrm_r;
      s4_last_r <= s3_last_r;
      s4_lead_r <= lead_nxt;
      s4_zero_r <= (mag_or == '0);
    end
  end

  // Stage 5: align so the largest magnitude has its top bit at bit TOPB
  vat_pkg::vat_side_t s5_side_nxt;

  always_comb begin
    logic [vat_pkg::NSUM_W-1:0] shifted;
    s5_side_nxt.pos    = s4_pos_r;
    s5_side_nxt.nrm_in = s4_nrm_r;
    s5_side_nxt.last   = s4_last_r;
    s5_side_nxt.en     = nrm_en_r;
    s5_side_nxt.zero   = s4_zero_r;
    s5_side_nxt.neg    = s4_neg_r;
    for (int i = 0; i < 3; i++) begin
      if (s4_lead_r >= vat_pkg::LEAD_W'(TOPB)) begin
        shifted = s4_mag_r[i] >> (s4_lead_r - vat_pkg::LEAD_W'(TOPB));
      end else begin
        shifted = s4_mag_r[i] << (vat_pkg::LEAD_W'(TOPB) - s4_lead_r);
      end
      s5_side_nxt.mag[i] = shifted[vat_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_side_r <= s5_side_nxt;
    end
  end

  // Stage 6: squares; stage 7: sum of squares
  for (genvar i = 0; i < 3; i++) begin : g_s6
    logic [vat_pkg::SQ_W-1:0] sq;
    assign sq = s5_side_r.mag[i] * s5_side_r.mag[i];
    always_ff @(posedge clk) begin
      if (adv) begin
        s6_sq_r[i] <= sq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_side_r <= s5_side_r;
      s7_side_r <= s6_side_r;
      s7_rad_r  <= vat_pkg::RAD_W'(s6_sq_r[0]) + vat_pkg::RAD_W'(s6_sq_r[1])
                 + vat_pkg::RAD_W'(s6_sq_r[2]);
    end
  end

  assign sq_ctl = '{vld: s7_vld_r, adv: adv};

  vat_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (sq_ctl),
    .rad_i  (s7_rad_r),
    .side_i (s7_side_r),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  assign dv_ctl = '{vld: sq_vld, adv: adv};

  vat_recip_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (dv_ctl),
    .len_i  (sq_root),
    .side_i (sq_side),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  // Output register: apply sign, zero length and pass-through
  always_comb begin
    logic [N_W-1:0] q;
    for (int i = 0; i < 3; i++) begin
      out_tdata_nxt[P_W*i +: P_W] = dv_side.pos[i];
      q = N_W'(dv_quo[i]);
      if (!dv_side.en) begin
        out_tdata_nxt[3*P_W + N_W*i +: N_W] = dv_side.nrm_in[i];
      end else if (dv_side.zero) begin
        out_tdata_nxt[3*P_W + N_W*i +: N_W] = '0;
      end else begin
        out_tdata_nxt[3*P_W + N_W*i +: N_W] = dv_side.neg[i] ? N_W'(-q) : q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= out_tdata_nxt;
      out_tlast_r <= dv_side.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_norm_align: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_vld_r && !s5_side_r.zero) |->
      (s5_side_r.mag[0][TOPB] || s5_side_r.mag[1][TOPB] || s5_side_r.mag[2][TOPB]))
    else $error("normal magnitudes not aligned to the top bit");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld && dv_side.en && !dv_side.zero) |->
      (dv_quo[0] <= vat_pkg::UNIT_Q) && (dv_quo[1] <= vat_pkg::UNIT_Q) &&
      (dv_quo[2] <= vat_pkg::UNIT_Q))
    else $error("normal component exceeds unit length");

endmodule
